// ----- hdl/prq_pkg.sv -----
// Shared types and codes for the policy ready queue.
package prq_pkg;

  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int WORK_W   = 32;
  localparam int SEQ_W    = 32;
  localparam int OCC_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_SJF  = 2'd2,
    MODE_RR   = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_DRAIN = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_QUANTUM = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [PRIO_W-1:0] prio;
    logic [WORK_W-1:0] work;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

endpackage

// ----- hdl/prq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/prq_pick.sv -----
// Winner selection: compares one stored entry per cycle against the running best.
module prq_pick import prq_pkg::*; #(
  parameter int AW = 5
) (
  input  logic          clk,
  input  mode_t         mode,
  input  logic          dvld,
  input  logic [AW-1:0] didx,
  input  entry_t        dent,
  output entry_t        best,
  output logic [AW-1:0] best_idx
);

  entry_t        best_r;
  logic [AW-1:0] best_idx_r;
  logic          take;

  always_comb begin
    take = 1'b0;
    case (mode)
      MODE_PRIO: begin
        if (dent.prio != best_r.prio) take = dent.prio > best_r.prio;
        else                          take = dent.seq < best_r.seq;
      end
      MODE_SJF: begin
        if (dent.work != best_r.work) take = dent.work < best_r.work;
        else                          take = dent.seq < best_r.seq;
      end
      default: take = 1'b0;
    endcase
    if (didx == '0) take = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (dvld && take) begin
      best_r     <= dent;
      best_idx_r <= didx;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

// ----- hdl/policy_ready_queue.sv -----
// Ready queue of job entries held in arrival order in one RAM, with mode-selected pop order.
// Push, a nop, and a pop or drain on an empty queue need no scan and leave in_stall low
// (one per cycle while results are taken). A pop of a queue holding N entries keeps in_stall
// high while it reads all N entries in priority and shortest-job modes, or only the head in
// FIFO and round-robin modes, then presents the result beat and moves the entries behind the
// winner down by one, all N-1 others in FIFO order. One RAM read per cycle drives both the
// winner scan (one comparator) and the compaction of the entries behind the winner. A drain
// repeats that per stored entry and emits one result per entry, the last one marked; each of
// its beats also waits while out_stall holds the previous one.
module policy_ready_queue import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_W-1:0]      in_job_id,
  input  logic [PRIO_W-1:0]    in_priority_req,
  input  logic [WORK_W-1:0]    in_work_units,
  input  logic [SEQ_W-1:0]     in_sequence_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_entry_valid,
  output logic [ID_W-1:0]      out_job_id,
  output logic [PRIO_W-1:0]    out_priority,
  output logic [WORK_W-1:0]    out_work_units,
  output logic [SEQ_W-1:0]     out_sequence,
  output logic                 out_last,
  output logic [OCC_W-1:0]     out_occupancy,
  output logic [WORK_W-1:0]    out_slice_quota,
  output logic                 out_slice_unlimited
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  state_t            state_r, state_nxt;
  mode_t             mode_r;
  logic [WORK_W-1:0] quantum_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              drain_r, drain_nxt;

  logic              ovalid_r, ovalid_nxt;
  status_t           ostatus_r, ostatus_nxt;
  logic              oentv_r, oentv_nxt;
  entry_t            oent_r, oent_nxt;
  logic              olast_r, olast_nxt;
  logic [CNT_W-1:0]  oocc_r, oocc_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  entry_t            best;
  logic [AW-1:0]     best_idx;
  entry_t            in_ent;
  logic              in_acc, out_free, ranked;
  logic [CNT_W-1:0]  lim;

  prq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prq_pick #(
    .AW (AW)
  ) u_pick (
    .clk      (clk),
    .mode     (mode_r),
    .dvld     (pend_r && (state_r == S_SCAN)),
    .didx     (pidx_r),
    .dent     (ram_rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  assign in_ent   = '{job_id: in_job_id, prio: in_priority_req,
                      work: in_work_units, seq: in_sequence_req};
  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign ranked   = (mode_r == MODE_PRIO) || (mode_r == MODE_SJF);
  assign lim      = ranked ? count_r : CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FIFO;
      quantum_r <= WORK_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode_r <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_QUANTUM: if (cfg_wdata != '0) quantum_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ptr_r    <= '0;
      pend_r   <= 1'b0;
      drain_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      pend_r   <= pend_nxt;
      drain_r  <= drain_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r    <= pidx_nxt;
    ostatus_r <= ostatus_nxt;
    oentv_r   <= oentv_nxt;
    oent_r    <= oent_nxt;
    olast_r   <= olast_nxt;
    oocc_r    <= oocc_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = pidx_r;
    drain_nxt   = drain_r;
    ovalid_nxt  = ovalid_r && out_stall;
    ostatus_nxt = ostatus_r;
    oentv_nxt   = oentv_r;
    oent_nxt    = oent_r;
    olast_nxt   = olast_r;
    oocc_nxt    = oocc_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = in_ent;
    ram_re      = 1'b0;
    ram_raddr   = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ovalid_nxt  = 1'b1;
          oentv_nxt   = 1'b0;
          oent_nxt    = '0;
          olast_nxt   = 1'b1;
          ostatus_nxt = ST_OK;
          oocc_nxt    = count_r;
          case (kind_t'(in_kind))
            KIND_PUSH: begin
              if (count_r < DEPTH_C) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                oocc_nxt  = count_r + CNT_W'(1);
              end else begin
                ostatus_nxt = ST_FULL;
              end
            end
            KIND_POP, KIND_DRAIN: begin
              if (count_r == '0) begin
                ostatus_nxt = ST_EMPTY;
              end else begin
                ovalid_nxt = ovalid_r && out_stall;
                drain_nxt  = (kind_t'(in_kind) == KIND_DRAIN);
                ptr_nxt    = '0;
                state_nxt  = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_r < lim) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          oentv_nxt   = 1'b1;
          oent_nxt    = best;
          olast_nxt   = !(drain_r && (count_r > CNT_W'(1)));
          oocc_nxt    = count_r - CNT_W'(1);
          count_nxt   = count_r - CNT_W'(1);
          ptr_nxt     = CNT_W'(best_idx) + CNT_W'(1);
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // entries behind the winner move down by one
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_r <= count_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = ptr_r[AW-1:0];
          ptr_nxt  = ptr_r + CNT_W'(1);
        end else if (!pend_r) begin
          if (drain_r && (count_r != '0)) begin
            ptr_nxt   = '0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = ovalid_r;
  assign out_status          = ostatus_r;
  assign out_entry_valid     = oentv_r;
  assign out_job_id          = oent_r.job_id;
  assign out_priority        = oent_r.prio;
  assign out_work_units      = oent_r.work;
  assign out_sequence        = oent_r.seq;
  assign out_last            = olast_r;
  assign out_occupancy       = OCC_W'(oocc_r);
  assign out_slice_quota     = (mode_r == MODE_RR) ? quantum_r : '0;
  assign out_slice_unlimited = (mode_r != MODE_RR);

endmodule

// ----- hdl/prq_chk.sv -----
// Port-level checks for the policy ready queue, bound to the top level.
module prq_chk import prq_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_entry_valid,
  input logic [ID_W-1:0]     out_job_id,
  input logic [WORK_W-1:0]   out_work_units,
  input logic [SEQ_W-1:0]    out_sequence,
  input logic                out_last,
  input logic [WORK_W-1:0]   out_slice_quota,
  input logic                out_slice_unlimited
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_job_id) && $stable(out_status)
                               && $stable(out_last))
    else $error("stalled result beat changed");

  a_noent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |->
      out_job_id == '0 && out_work_units == '0 && out_sequence == '0)
    else $error("result without entry carries nonzero entry fields");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_last && !out_entry_valid)
    else $error("empty status beat must be a single last beat without entry");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_status == ST_OK)
    else $error("removed entry reported with error status");

  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slice_unlimited == (out_slice_quota == '0))
    else $error("slice quota and unlimited flag disagree");

endmodule

bind policy_ready_queue prq_chk u_prq_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_entry_valid     (out_entry_valid),
  .out_job_id          (out_job_id),
  .out_work_units      (out_work_units),
  .out_sequence        (out_sequence),
  .out_last            (out_last),
  .out_slice_quota     (out_slice_quota),
  .out_slice_unlimited (out_slice_unlimited)
);
